[src/macd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the MACD crossover trader.
// No dependencies; every other file refers to this package by scoped names.
package macd_pkg;

    localparam int PRICE_W = 32;
    localparam int ALPHA_W = 17;
    localparam int LIMIT_W = 10;
    localparam int POS_W   = 11;
    localparam int MACD_W  = 33;
    localparam int SIG_W   = 34;
    localparam int BAL_W   = 64;
    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 35;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int FRAC_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

    localparam logic [ALPHA_W-1:0] ALPHA_LONG_RST   = 17'd4096;
    localparam logic [ALPHA_W-1:0] ALPHA_SHORT_RST  = 17'd8192;
    localparam logic [ALPHA_W-1:0] ALPHA_SIGNAL_RST = 17'd13107;
    localparam logic [LIMIT_W-1:0] MAX_POS_RST      = 10'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA_LONG   = 2'd0,
        REG_ALPHA_SHORT  = 2'd1,
        REG_ALPHA_SIGNAL = 2'd2,
        REG_MAX_POSITION = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_BUY  = 2'd1,
        ACT_SELL = 2'd2
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_MUL_LONG,
        ST_UPD_LONG,
        ST_UPD_SHORT,
        ST_MACD,
        ST_MUL_SIG,
        ST_UPD_SIG,
        ST_TRADE,
        ST_SQ_MUL,
        ST_SQ_ADD,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SEED,
        OP_MUL_LONG,
        OP_UPD_LONG,
        OP_UPD_SHORT,
        OP_MACD,
        OP_MUL_SIG,
        OP_UPD_SIG,
        OP_TRADE,
        OP_SQ_MUL,
        OP_SQ_ADD,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic start;
        logic last;
        logic out_free;
    } dp_status_t;

endpackage

[src/macd_ifs.sv]
`timescale 1ns / 1ps
// Valid/ready channels for price items and result items.
// Depends on macd_pkg for field widths.
interface macd_price_if;
    logic                         valid;
    logic                         ready;
    logic [macd_pkg::PRICE_W-1:0] close_price;
    logic                         start_flag;
    logic                         end_flag;

    modport source (output valid, close_price, start_flag, end_flag, input ready);
    modport sink (input valid, close_price, start_flag, end_flag, output ready);
endinterface

interface macd_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [macd_pkg::MACD_W-1:0] macd_value;
    logic signed [macd_pkg::MACD_W-1:0] signal_value;
    logic [1:0]                         trade_action;
    logic                               squared_off;
    logic signed [macd_pkg::POS_W-1:0]  position_now;
    logic signed [macd_pkg::BAL_W-1:0]  balance_now;

    modport source (output valid, macd_value, signal_value, trade_action, squared_off,
                    position_now, balance_now, input ready);
    modport sink (input valid, macd_value, signal_value, trade_action, squared_off,
                  position_now, balance_now, output ready);
endinterface

[src/macd_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the trader: steps one item through the shared multiplier.
// Depends on macd_pkg for the state, command and status types.
module macd_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  macd_pkg::dp_status_t  status,
    output macd_pkg::dp_cmd_t     cmd
);

    macd_pkg::ctrl_state_t state_reg;
    macd_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= macd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.op     = macd_pkg::OP_NONE;
        unique case (state_reg)
            macd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = macd_pkg::OP_LOAD;
                    state_next = macd_pkg::ST_SEED;
                end
            end
            macd_pkg::ST_SEED:
            begin
                // A start item skips the averaging and trading steps.
                if (status.start)
                begin
                    cmd.op     = macd_pkg::OP_SEED;
                    state_next = status.last ? macd_pkg::ST_SQ_MUL : macd_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = macd_pkg::ST_MUL_LONG;
                end
            end
            macd_pkg::ST_MUL_LONG:
            begin
                cmd.op     = macd_pkg::OP_MUL_LONG;
                state_next = macd_pkg::ST_UPD_LONG;
            end
            macd_pkg::ST_UPD_LONG:
            begin
                cmd.op     = macd_pkg::OP_UPD_LONG;
                state_next = macd_pkg::ST_UPD_SHORT;
            end
            macd_pkg::ST_UPD_SHORT:
            begin
                cmd.op     = macd_pkg::OP_UPD_SHORT;
                state_next = macd_pkg::ST_MACD;
            end
            macd_pkg::ST_MACD:
            begin
                cmd.op     = macd_pkg::OP_MACD;
                state_next = macd_pkg::ST_MUL_SIG;
            end
            macd_pkg::ST_MUL_SIG:
            begin
                cmd.op     = macd_pkg::OP_MUL_SIG;
                state_next = macd_pkg::ST_UPD_SIG;
            end
            macd_pkg::ST_UPD_SIG:
            begin
                cmd.op     = macd_pkg::OP_UPD_SIG;
                state_next = macd_pkg::ST_TRADE;
            end
            macd_pkg::ST_TRADE:
            begin
                cmd.op     = macd_pkg::OP_TRADE;
                state_next = status.last ? macd_pkg::ST_SQ_MUL : macd_pkg::ST_EMIT;
            end
            macd_pkg::ST_SQ_MUL:
            begin
                cmd.op     = macd_pkg::OP_SQ_MUL;
                state_next = macd_pkg::ST_SQ_ADD;
            end
            macd_pkg::ST_SQ_ADD:
            begin
                cmd.op     = macd_pkg::OP_SQ_ADD;
                state_next = macd_pkg::ST_EMIT;
            end
            macd_pkg::ST_EMIT:
            begin
                // Wait until the output register is empty or being drained.
                if (status.out_free)
                begin
                    cmd.op     = macd_pkg::OP_EMIT;
                    state_next = macd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = macd_pkg::ST_IDLE;
            end
        endcase
    end

    ast_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (cmd.op == macd_pkg::OP_NONE || cmd.op == macd_pkg::OP_LOAD))
        else $error("input ready outside of the idle state");

    ast_load_then_seed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == macd_pkg::OP_LOAD |=> state_reg == macd_pkg::ST_SEED)
        else $error("accepted item did not enter the seed check");

    ast_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == macd_pkg::OP_EMIT |-> status.out_free)
        else $error("result written while output register was full");

endmodule

[src/macd_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the trader: averages, signal line, position, balance, one shared
// multiplier, configuration registers and the output register. Uses macd_pkg.
module macd_datapath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  macd_pkg::dp_cmd_t                      cmd,
    output macd_pkg::dp_status_t                   status,
    input  logic                                   cfg_we,
    input  logic [macd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [macd_pkg::ALPHA_W-1:0]           cfg_data,
    input  logic [macd_pkg::PRICE_W-1:0]           close_price,
    input  logic                                   start_flag,
    input  logic                                   end_flag,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [macd_pkg::MACD_W-1:0]     macd_value,
    output logic signed [macd_pkg::MACD_W-1:0]     signal_value,
    output logic [1:0]                             trade_action,
    output logic                                   squared_off,
    output logic signed [macd_pkg::POS_W-1:0]      position_now,
    output logic signed [macd_pkg::BAL_W-1:0]      balance_now
);

    localparam int SHIFT_W = macd_pkg::PROD_W - macd_pkg::FRAC_W;

    // Configuration registers.
    logic [macd_pkg::ALPHA_W-1:0] alpha_long_reg;
    logic [macd_pkg::ALPHA_W-1:0] alpha_short_reg;
    logic [macd_pkg::ALPHA_W-1:0] alpha_signal_reg;
    logic [macd_pkg::LIMIT_W-1:0] max_pos_reg;
    logic [macd_pkg::ALPHA_W-1:0] cfg_alpha;

    // Trader state.
    logic [macd_pkg::PRICE_W-1:0]       long_reg;
    logic [macd_pkg::PRICE_W-1:0]       short_reg;
    logic signed [macd_pkg::SIG_W-1:0]  sig_reg;
    logic signed [macd_pkg::POS_W-1:0]  held_reg;
    logic signed [macd_pkg::BAL_W-1:0]  bal_reg;

    // Per-item working registers.
    logic [macd_pkg::PRICE_W-1:0]       price_reg;
    logic                               start_reg;
    logic                               last_reg;
    logic signed [macd_pkg::MACD_W-1:0] macd_reg;
    logic signed [macd_pkg::PROD_W-1:0] prod_reg;
    logic [1:0]                         action_reg;
    logic                               closed_reg;

    // Output register.
    logic                               out_valid_reg;
    logic signed [macd_pkg::MACD_W-1:0] out_macd_reg;
    logic signed [macd_pkg::MACD_W-1:0] out_sig_reg;
    logic [1:0]                         out_action_reg;
    logic                               out_closed_reg;
    logic signed [macd_pkg::POS_W-1:0]  out_pos_reg;
    logic signed [macd_pkg::BAL_W-1:0]  out_bal_reg;

    logic signed [macd_pkg::MUL_A_W-1:0] mul_a;
    logic signed [macd_pkg::MUL_B_W-1:0] mul_b;
    logic signed [macd_pkg::PROD_W-1:0]  mul_p;
    logic signed [macd_pkg::MACD_W-1:0]  diff_long;
    logic signed [macd_pkg::MACD_W-1:0]  diff_short;
    logic signed [macd_pkg::MUL_B_W-1:0] diff_sig;
    logic signed [SHIFT_W-1:0]           step;
    logic signed [SHIFT_W-1:0]           long_sum;
    logic signed [SHIFT_W-1:0]           short_sum;
    logic signed [SHIFT_W-1:0]           sig_sum;
    logic signed [macd_pkg::SIG_W-1:0]   macd_ext;
    logic signed [macd_pkg::POS_W-1:0]   limit;
    logic signed [macd_pkg::POS_W-1:0]   neg_limit;
    logic                                buy;
    logic                                sell;
    logic signed [macd_pkg::BAL_W-1:0]   price_wide;
    logic signed [macd_pkg::BAL_W-1:0]   trade_delta;
    logic signed [macd_pkg::BAL_W-1:0]   trade_bal;
    logic signed [macd_pkg::BAL_W-1:0]   square_delta;
    logic signed [macd_pkg::BAL_W-1:0]   square_bal;

    function automatic logic signed [macd_pkg::BAL_W-1:0] sat_add(
        input logic signed [macd_pkg::BAL_W-1:0] a,
        input logic signed [macd_pkg::BAL_W-1:0] b
    );
        logic signed [macd_pkg::BAL_W:0] sum;
        logic signed [macd_pkg::BAL_W-1:0] result;
        sum = {a[macd_pkg::BAL_W-1], a} + {b[macd_pkg::BAL_W-1], b};
        if (sum[macd_pkg::BAL_W] != sum[macd_pkg::BAL_W-1])
        begin
            // Overflow: clamp toward the sign of the true sum.
            result = sum[macd_pkg::BAL_W] ? {1'b1, {(macd_pkg::BAL_W-1){1'b0}}}
                                          : {1'b0, {(macd_pkg::BAL_W-1){1'b1}}};
        end
        else
        begin
            result = sum[macd_pkg::BAL_W-1:0];
        end
        return result;
    endfunction

    // Alphas above one are stored as one, which keeps the averages in range.
    assign cfg_alpha = (cfg_data > macd_pkg::ALPHA_ONE) ? macd_pkg::ALPHA_ONE : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_long_reg   <= macd_pkg::ALPHA_LONG_RST;
            alpha_short_reg  <= macd_pkg::ALPHA_SHORT_RST;
            alpha_signal_reg <= macd_pkg::ALPHA_SIGNAL_RST;
            max_pos_reg      <= macd_pkg::MAX_POS_RST;
        end
        else if (cfg_we)
        begin
            unique case (macd_pkg::cfg_index_t'(cfg_index))
                macd_pkg::REG_ALPHA_LONG:   alpha_long_reg   <= cfg_alpha;
                macd_pkg::REG_ALPHA_SHORT:  alpha_short_reg  <= cfg_alpha;
                macd_pkg::REG_ALPHA_SIGNAL: alpha_signal_reg <= cfg_alpha;
                macd_pkg::REG_MAX_POSITION:
                    max_pos_reg <= cfg_data[macd_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign diff_long  = $signed({1'b0, price_reg}) - $signed({1'b0, long_reg});
    assign diff_short = $signed({1'b0, price_reg}) - $signed({1'b0, short_reg});
    assign diff_sig   = {{2{macd_reg[macd_pkg::MACD_W-1]}}, macd_reg}
                        - {sig_reg[macd_pkg::SIG_W-1], sig_reg};

    // Operand selection for the one shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            macd_pkg::OP_MUL_LONG:
            begin
                mul_a = $signed({1'b0, alpha_long_reg});
                mul_b = {{2{diff_long[macd_pkg::MACD_W-1]}}, diff_long};
            end
            macd_pkg::OP_UPD_LONG:
            begin
                mul_a = $signed({1'b0, alpha_short_reg});
                mul_b = {{2{diff_short[macd_pkg::MACD_W-1]}}, diff_short};
            end
            macd_pkg::OP_MUL_SIG:
            begin
                mul_a = $signed({1'b0, alpha_signal_reg});
                mul_b = diff_sig;
            end
            macd_pkg::OP_SQ_MUL:
            begin
                mul_a = {{(macd_pkg::MUL_A_W-macd_pkg::POS_W){held_reg[macd_pkg::POS_W-1]}},
                         held_reg};
                mul_b = $signed({3'b000, price_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Arithmetic shift by the fraction width rounds toward minus infinity.
    assign step      = prod_reg[macd_pkg::PROD_W-1:macd_pkg::FRAC_W];
    assign long_sum  = $signed({5'b0, long_reg}) + step;
    assign short_sum = $signed({5'b0, short_reg}) + step;
    assign sig_sum   = {{(SHIFT_W-macd_pkg::SIG_W){sig_reg[macd_pkg::SIG_W-1]}}, sig_reg}
                       + step;

    assign macd_ext  = {macd_reg[macd_pkg::MACD_W-1], macd_reg};
    assign limit     = $signed({1'b0, max_pos_reg});
    assign neg_limit = -limit;
    assign buy       = (macd_ext > sig_reg) && (held_reg < limit);
    assign sell      = (macd_ext < sig_reg) && (held_reg > neg_limit);

    assign price_wide   = $signed({32'b0, price_reg});
    assign trade_delta  = buy ? -price_wide : price_wide;
    assign trade_bal    = sat_add(bal_reg, trade_delta);
    assign square_delta = {{(macd_pkg::BAL_W-macd_pkg::PROD_W){prod_reg[macd_pkg::PROD_W-1]}},
                           prod_reg};
    assign square_bal   = sat_add(bal_reg, square_delta);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_reg   <= '0;
            short_reg  <= '0;
            sig_reg    <= '0;
            held_reg   <= '0;
            bal_reg    <= '0;
            start_reg  <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                macd_pkg::OP_LOAD:
                begin
                    start_reg <= start_flag;
                    last_reg  <= end_flag;
                end
                macd_pkg::OP_SEED:
                begin
                    long_reg  <= price_reg;
                    short_reg <= price_reg;
                    sig_reg   <= '0;
                end
                macd_pkg::OP_UPD_LONG:
                begin
                    long_reg <= long_sum[macd_pkg::PRICE_W-1:0];
                end
                macd_pkg::OP_UPD_SHORT:
                begin
                    short_reg <= short_sum[macd_pkg::PRICE_W-1:0];
                end
                macd_pkg::OP_UPD_SIG:
                begin
                    sig_reg <= sig_sum[macd_pkg::SIG_W-1:0];
                end
                macd_pkg::OP_TRADE:
                begin
                    if (buy)
                    begin
                        held_reg <= held_reg + 11'sd1;
                        bal_reg  <= trade_bal;
                    end
                    else if (sell)
                    begin
                        held_reg <= held_reg - 11'sd1;
                        bal_reg  <= trade_bal;
                    end
                end
                macd_pkg::OP_SQ_ADD:
                begin
                    held_reg <= '0;
                    bal_reg  <= square_bal;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            macd_pkg::OP_LOAD:
            begin
                price_reg  <= close_price;
                macd_reg   <= '0;
                action_reg <= macd_pkg::ACT_NONE;
                closed_reg <= 1'b0;
            end
            macd_pkg::OP_MUL_LONG, macd_pkg::OP_UPD_LONG, macd_pkg::OP_MUL_SIG,
            macd_pkg::OP_SQ_MUL:
            begin
                prod_reg <= mul_p;
            end
            macd_pkg::OP_MACD:
            begin
                macd_reg <= $signed({1'b0, short_reg}) - $signed({1'b0, long_reg});
            end
            macd_pkg::OP_TRADE:
            begin
                action_reg <= buy ? macd_pkg::ACT_BUY
                            : (sell ? macd_pkg::ACT_SELL : macd_pkg::ACT_NONE);
            end
            macd_pkg::OP_SQ_ADD:
            begin
                closed_reg <= (held_reg != '0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == macd_pkg::OP_EMIT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == macd_pkg::OP_EMIT)
        begin
            out_macd_reg   <= macd_reg;
            out_sig_reg    <= sig_reg[macd_pkg::MACD_W-1:0];
            out_action_reg <= action_reg;
            out_closed_reg <= closed_reg;
            out_pos_reg    <= held_reg;
            out_bal_reg    <= bal_reg;
        end
    end

    assign status.start    = start_reg;
    assign status.last     = last_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign macd_value   = out_macd_reg;
    assign signal_value = out_sig_reg;
    assign trade_action = out_action_reg;
    assign squared_off  = out_closed_reg;
    assign position_now = out_pos_reg;
    assign balance_now  = out_bal_reg;

    ast_square_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == macd_pkg::OP_SQ_ADD |=> held_reg == '0)
        else $error("position not cleared by square-off");

    ast_trade_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == macd_pkg::OP_TRADE |=>
            (held_reg == $past(held_reg) || held_reg == $past(held_reg) + 11'sd1
             || held_reg == $past(held_reg) - 11'sd1))
        else $error("trade moved the position by more than one unit");

    ast_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.op == macd_pkg::OP_EMIT))
        else $error("result appeared without a write command");

    ast_no_bad_action: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_action_reg != 2'd3)
        else $error("undefined trade action on the output");

endmodule

[src/macd_crossover_trader.sv]
`timescale 1ns / 1ps
// Top level of the MACD signal-line crossover trader.
// Joins macd_ctrl and macd_datapath; uses macd_pkg and the channels in macd_ifs.
//
//   Port     Kind           Carries
//   price    valid/ready in close_price, start_flag, end_flag
//   report   valid/ready out macd_value, signal_value, trade_action, squared_off,
//                           position_now, balance_now
//   cfg_*    write only     alpha_long, alpha_short, alpha_signal, max_position
//
// An ordinary item passes the seed check, both average updates, the MACD step,
// the signal update and the trade step; a start item is only seeded. A last
// item then squares off. The steps share the one multiplier, and the next item
// can be accepted in the cycle after the result is written.
// Reset clears the averages, signal line, position and balance and loads the
// register defaults. A result waits in the output register while the next
// item is worked on; the block stalls only when a second result is ready first.
module macd_crossover_trader
(
    input  logic                               clk,
    input  logic                               rst_n,
    macd_price_if.sink                         price,
    macd_result_if.source                      report,
    input  logic                               cfg_we,
    input  logic [macd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [macd_pkg::ALPHA_W-1:0]       cfg_data
);

    macd_pkg::dp_cmd_t    cmd;
    macd_pkg::dp_status_t status;

    macd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (price.valid),
        .in_ready (price.ready),
        .status   (status),
        .cmd      (cmd)
    );

    macd_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .close_price  (price.close_price),
        .start_flag   (price.start_flag),
        .end_flag     (price.end_flag),
        .out_valid    (report.valid),
        .out_ready    (report.ready),
        .macd_value   (report.macd_value),
        .signal_value (report.signal_value),
        .trade_action (report.trade_action),
        .squared_off  (report.squared_off),
        .position_now (report.position_now),
        .balance_now  (report.balance_now)
    );

endmodule
